// ----- design/ocb2_pkg.sv -----
`timescale 1ns / 1ps
package ocb2_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_KEY_HI  = 3'd0,
    REG_KEY_LO  = 3'd1,
    REG_ENC_HI  = 3'd2,
    REG_ENC_LO  = 3'd3,
    REG_DEC_HI  = 3'd4,
    REG_DEC_LO  = 3'd5
  } reg_idx_t;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_NONCE = 7'b0000010,
    ST_BLOCK = 7'b0000100,
    ST_PAD   = 7'b0001000,
    ST_TAG   = 7'b0010000,
    ST_OUT   = 7'b0100000,
    ST_START = 7'b1000000
  } state_t;

  // Which pass the shared AES core is running
  typedef enum logic [1:0] {
    PASS_NONCE = 2'd0,
    PASS_BLOCK = 2'd1,
    PASS_PAD   = 2'd2,
    PASS_TAG   = 2'd3
  } pass_t;

  localparam logic [7:0] GF_POLY = 8'h87;

  // GF(2^8) multiply by x
  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // GF(2^8) multiply by a small constant (up to 4 bits)
  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gm = p;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] isbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    isbox = t[x];
  endfunction

  // Next round key; key schedule words w0..w3 to w4..w7
  function automatic logic [127:0] next_rk(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_rk = {w0, w1, w2, w3};
  endfunction

  // Previous round key; rc is the constant used to make k
  function automatic logic [127:0] prev_rk(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    w3 = w3 ^ w2;
    w2 = w2 ^ w1;
    w1 = w1 ^ w0;
    t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    prev_rk = {w0, w1, w2, w3};
  endfunction

  // Byte i of a big-endian block
  function automatic logic [7:0] bt(input logic [127:0] s, input int i);
    bt = s[127 - 8 * i -: 8];
  endfunction

  // Forward round: SubBytes, ShiftRows, optional MixColumns
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic mix);
    logic [7:0] t [16];
    logic [127:0] o;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[r + 4 * c] = sbox(bt(s, r + 4 * ((c + r) & 3)));
    for (int c = 0; c < 4; c++) begin
      if (mix) begin
        o[127 - 32 * c -: 8] = xt(t[4*c]) ^ gm(t[4*c+1], 4'd3) ^ t[4*c+2] ^ t[4*c+3];
        o[119 - 32 * c -: 8] = t[4*c] ^ xt(t[4*c+1]) ^ gm(t[4*c+2], 4'd3) ^ t[4*c+3];
        o[111 - 32 * c -: 8] = t[4*c] ^ t[4*c+1] ^ xt(t[4*c+2]) ^ gm(t[4*c+3], 4'd3);
        o[103 - 32 * c -: 8] = gm(t[4*c], 4'd3) ^ t[4*c+1] ^ t[4*c+2] ^ xt(t[4*c+3]);
      end else begin
        o[127 - 32 * c -: 8] = t[4*c];
        o[119 - 32 * c -: 8] = t[4*c+1];
        o[111 - 32 * c -: 8] = t[4*c+2];
        o[103 - 32 * c -: 8] = t[4*c+3];
      end
    end
    enc_round = o;
  endfunction

  // Inverse round: InvShiftRows, InvSubBytes, AddRoundKey, optional InvMixColumns
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic mix);
    logic [7:0] t [16];
    logic [7:0] a [16];
    logic [127:0] o;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[r + 4 * ((c + r) & 3)] = bt(s, r + 4 * c);
    for (int j = 0; j < 16; j++) a[j] = isbox(t[j]) ^ bt(rk, j);
    for (int c = 0; c < 4; c++) begin
      if (mix) begin
        o[127 - 32 * c -: 8] = gm(a[4*c], 4'd14) ^ gm(a[4*c+1], 4'd11) ^
                               gm(a[4*c+2], 4'd13) ^ gm(a[4*c+3], 4'd9);
        o[119 - 32 * c -: 8] = gm(a[4*c], 4'd9) ^ gm(a[4*c+1], 4'd14) ^
                               gm(a[4*c+2], 4'd11) ^ gm(a[4*c+3], 4'd13);
        o[111 - 32 * c -: 8] = gm(a[4*c], 4'd13) ^ gm(a[4*c+1], 4'd9) ^
                               gm(a[4*c+2], 4'd14) ^ gm(a[4*c+3], 4'd11);
        o[103 - 32 * c -: 8] = gm(a[4*c], 4'd11) ^ gm(a[4*c+1], 4'd13) ^
                               gm(a[4*c+2], 4'd9) ^ gm(a[4*c+3], 4'd14);
      end else begin
        o[127 - 32 * c -: 8] = a[4*c];
        o[119 - 32 * c -: 8] = a[4*c+1];
        o[111 - 32 * c -: 8] = a[4*c+2];
        o[103 - 32 * c -: 8] = a[4*c+3];
      end
    end
    dec_round = o;
  endfunction

  // Doubling in GF(2^128)
  function automatic logic [127:0] gf_dbl(input logic [127:0] v);
    gf_dbl = {v[126:0], 1'b0} ^ {120'd0, (v[127] ? GF_POLY : 8'h00)};
  endfunction

endpackage

// ----- design/ocb2_aes128_authenticated_cipher_top.sv -----
`timescale 1ns / 1ps
// Channel | Handshake          | Payload
// in      | in_valid/in_ready  | in_cmd, in_block_high/low, in_last, in_tail_bytes
// out     | out_valid/out_ready| out_out_high/low, out_tag_high/low, out_tag_valid
// cfg     | APB psel/penable   | paddr (6 regs at 8*i), pwdata/prdata 64 bit
// One shared AES round unit does one round per cycle. An inverse pass first walks the
// key schedule forward to rebuild the last round key, then runs its rounds backward.
// A middle block runs a block pass; a final block runs a pad pass then a tag pass;
// a message's first block adds a nonce pass before these.
// in_ready is high only in idle; the result waits in a register until out_ready.
// Reset is synchronous.
module ocb2_aes128_authenticated_cipher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        in_last,
  input  logic [3:0]  in_tail_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_out_high,
  output logic [63:0] out_out_low,
  output logic [63:0] out_tag_high,
  output logic [63:0] out_tag_low,
  output logic        out_tag_valid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [63:0] key_hi_r, key_lo_r, enc_hi_r, enc_lo_r, dec_hi_r, dec_lo_r;
  logic [2:0]  reg_idx;
  assign reg_idx = paddr[5:3];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0; key_lo_r <= '0; enc_hi_r <= '0;
      enc_lo_r <= '0; dec_hi_r <= '0; dec_lo_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        ocb2_pkg::REG_KEY_HI: key_hi_r <= pwdata;
        ocb2_pkg::REG_KEY_LO: key_lo_r <= pwdata;
        ocb2_pkg::REG_ENC_HI: enc_hi_r <= pwdata;
        ocb2_pkg::REG_ENC_LO: enc_lo_r <= pwdata;
        ocb2_pkg::REG_DEC_HI: dec_hi_r <= pwdata;
        ocb2_pkg::REG_DEC_LO: dec_lo_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ocb2_pkg::REG_KEY_HI: prdata = key_hi_r;
      ocb2_pkg::REG_KEY_LO: prdata = key_lo_r;
      ocb2_pkg::REG_ENC_HI: prdata = enc_hi_r;
      ocb2_pkg::REG_ENC_LO: prdata = enc_lo_r;
      ocb2_pkg::REG_DEC_HI: prdata = dec_hi_r;
      ocb2_pkg::REG_DEC_LO: prdata = dec_lo_r;
      default:              prdata = '0;
    endcase
  end

  // Datapath and sequencer registers
  ocb2_pkg::state_t st_r, st_nxt;
  ocb2_pkg::pass_t  pass_r;
  logic [127:0] s_r, rk_r, off_r, csum_r, blk_r, res_r;
  logic [7:0]   rc_r;
  logic [3:0]   rnd_r;
  logic         dir_r;    // 1: inverse cipher
  logic         rewind_r; // walking round keys forward before inverse pass
  logic         in_msg_r, cmd_r, last_r;
  logic [3:0]   nb_r;
  logic [127:0] key;
  assign key = {key_hi_r, key_lo_r};

  assign in_ready = st_r == ocb2_pkg::ST_IDLE;
  assign out_valid = st_r == ocb2_pkg::ST_OUT;

  // Tail masks for final block
  logic [127:0] tmask;
  always_comb begin
    for (int i = 0; i < 16; i++)
      tmask[127 - 8 * i -: 8] = (i < int'(nb_r)) ? 8'hff : 8'h00;
  end

  // Shared round unit
  logic [127:0] rk_fwd, rk_bwd, efw, ebw;
  logic [7:0]   rc_fwd, rc_bwd;
  assign rk_fwd = ocb2_pkg::next_rk(rk_r, rc_r);
  assign rc_fwd = ocb2_pkg::xt(rc_r);
  // in inverse passes rc_r holds constant that made rk_r; step back by multiplying by x^-1
  assign rc_bwd = rc_r[0] ? ({1'b0, rc_r[7:1]} ^ 8'h8d) : {1'b0, rc_r[7:1]};
  assign rk_bwd = ocb2_pkg::prev_rk(rk_r, rc_r);
  assign efw = ocb2_pkg::enc_round(s_r, rnd_r != 4'd10) ^ rk_fwd;
  assign ebw = ocb2_pkg::dec_round(s_r, rk_bwd, rnd_r != 4'd1);

  // Start an AES pass: input state pass_in, direction pass_dir
  logic [127:0] pass_in;
  logic         pass_dir;
  logic         pass_go;
  ocb2_pkg::pass_t pass_sel;
  logic [127:0] off2, pad_in, mtext, csum_fin, tag_in, blk_out;
  assign off2 = ocb2_pkg::gf_dbl(off_r);
  assign pad_in = off2 ^ {121'd0, nb_r, 3'b000};
  assign mtext = ((blk_r ^ s_r) & tmask) | (s_r & ~tmask);
  assign csum_fin = csum_r ^ (cmd_r ? mtext : ((blk_r & tmask) | (s_r & ~tmask)));
  assign tag_in = csum_fin ^ off2 ^ off_r;
  assign blk_out = s_r ^ off_r;

  // Pass finished: state holds the full cipher output
  logic busy_done;
  assign busy_done = !rewind_r && rnd_r == (dir_r ? 4'd0 : 4'd11);

  always_comb begin
    st_nxt = st_r;
    pass_go = 1'b0;
    pass_in = '0;
    pass_dir = 1'b0;
    pass_sel = ocb2_pkg::PASS_BLOCK;
    unique case (st_r)
      ocb2_pkg::ST_IDLE:
        if (in_valid) st_nxt = ocb2_pkg::ST_START;
      ocb2_pkg::ST_START: begin
        pass_go = 1'b1;
        if (!in_msg_r) begin
          pass_sel = ocb2_pkg::PASS_NONCE;
          pass_in = cmd_r ? {dec_hi_r, dec_lo_r} : {enc_hi_r, enc_lo_r};
          st_nxt = ocb2_pkg::ST_NONCE;
        end else if (last_r) begin
          pass_sel = ocb2_pkg::PASS_PAD;
          pass_in = pad_in;
          st_nxt = ocb2_pkg::ST_PAD;
        end else begin
          pass_sel = ocb2_pkg::PASS_BLOCK;
          pass_in = blk_r ^ off2;
          pass_dir = cmd_r;
          st_nxt = ocb2_pkg::ST_BLOCK;
        end
      end
      ocb2_pkg::ST_NONCE:
        if (busy_done) st_nxt = ocb2_pkg::ST_START;
      ocb2_pkg::ST_BLOCK:
        if (busy_done) st_nxt = ocb2_pkg::ST_OUT;
      ocb2_pkg::ST_PAD:
        if (busy_done) st_nxt = ocb2_pkg::ST_TAG;
      ocb2_pkg::ST_TAG:
        if (busy_done) st_nxt = ocb2_pkg::ST_OUT;
      ocb2_pkg::ST_OUT:
        if (out_ready) st_nxt = ocb2_pkg::ST_IDLE;
      default: st_nxt = ocb2_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ocb2_pkg::ST_IDLE;
      in_msg_r <= 1'b0;
      off_r <= '0;
      csum_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ocb2_pkg::ST_IDLE && in_valid) begin
        cmd_r <= in_cmd;
        blk_r <= {in_block_high, in_block_low};
        last_r <= in_last;
        nb_r <= in_tail_bytes;
      end
      if (pass_go) begin
        pass_r <= pass_sel;
        dir_r <= pass_dir;
        rewind_r <= pass_dir;
        rk_r <= key;
        rc_r <= 8'h01;
        if (pass_dir) begin
          s_r <= pass_in;
          rnd_r <= 4'd0;
        end else begin
          s_r <= pass_in ^ key;
          rnd_r <= 4'd1;
        end
        if (in_msg_r) off_r <= off2;
      end else if (st_r == ocb2_pkg::ST_NONCE || st_r == ocb2_pkg::ST_BLOCK ||
                   st_r == ocb2_pkg::ST_PAD || st_r == ocb2_pkg::ST_TAG) begin
        if (rewind_r) begin
          // derive round key 10; keep the constant that made it
          rk_r <= rk_fwd;
          rnd_r <= rnd_r + 4'd1;
          if (rnd_r == 4'd9) begin
            rewind_r <= 1'b0;
            s_r <= s_r ^ rk_fwd;
          end else begin
            rc_r <= rc_fwd;
          end
        end else if (!busy_done) begin
          if (dir_r) begin
            s_r <= ebw;
            rk_r <= rk_bwd;
            rc_r <= rc_bwd;
            rnd_r <= rnd_r - 4'd1;
          end else begin
            s_r <= efw;
            rk_r <= rk_fwd;
            rc_r <= rc_fwd;
            rnd_r <= rnd_r + 4'd1;
          end
        end
        if (busy_done) begin
          unique case (pass_r)
            ocb2_pkg::PASS_NONCE: begin
              // nonce pass done: set offset, then run block work
              off_r <= s_r;
              csum_r <= '0;
              in_msg_r <= 1'b1;
            end
            ocb2_pkg::PASS_BLOCK: begin
              res_r <= blk_out;
              csum_r <= csum_r ^ (cmd_r ? blk_out : blk_r);
            end
            ocb2_pkg::PASS_PAD: begin
              res_r <= (blk_r ^ s_r) & tmask;
              csum_r <= csum_fin;
              pass_r <= ocb2_pkg::PASS_TAG;
              s_r <= tag_in ^ key;
              rk_r <= key;
              rc_r <= 8'h01;
              rnd_r <= 4'd1;
            end
            ocb2_pkg::PASS_TAG: begin
              in_msg_r <= 1'b0;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Result fields; tag comes straight from the cipher state after the tag pass
  logic tag_now;
  assign tag_now = last_r;
  assign out_out_high = res_r[127:64];
  assign out_out_low  = res_r[63:0];
  assign out_tag_high = tag_now ? s_r[127:64] : 64'd0;
  assign out_tag_low  = tag_now ? s_r[63:0] : 64'd0;
  assign out_tag_valid = tag_now;

endmodule

// ----- design/ocb2_checker.sv -----
`timescale 1ns / 1ps
module ocb2_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_tag_high,
  input logic [63:0] out_tag_low,
  input logic        out_tag_valid,
  input logic        pready
);

  // No new beat accepted while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // No result is shown straight after a beat is accepted
  a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  // Tag is zero when it does not end a message
  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tag_valid) |-> (out_tag_high == 64'd0 && out_tag_low == 64'd0))
    else $error("tag set on middle block");

  // A held result stays valid with its upper tag word unchanged
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_tag_high)))
    else $error("result dropped");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind ocb2_aes128_authenticated_cipher_top ocb2_checker u_ocb2_checker (.*);
